FILE: sv/blar_pkg.sv
// Shared types and codes for the bounded append/remove list.
// No dependencies; used by blar_ctrl, blar_dp and bounded_list_append_remove.
package blar_pkg;

  localparam logic       CMD_APPEND = 1'b0;
  localparam logic       CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_APPENDED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_REMOVED  = 2'd2;
  localparam logic [1:0] ST_MISSING  = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

FILE: sv/blar_ctrl.sv
// Controller for the bounded list: sequences load and execute, owns word handshakes.
// Depends on blar_pkg; drives blar_dp through blar_pkg::dp_cmd_t.
module blar_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  output logic             result_valid,
  input  logic             result_stall,
  output blar_pkg::dp_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic result_valid_next;
  logic out_free;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next        = state;
    result_valid_next = result_valid && result_stall;
    cmd.load          = 1'b0;
    cmd.exec          = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec          = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

FILE: sv/blar_dp.sv
// Datapath for the bounded list: entry cells, count, totals and result word.
// Depends on blar_pkg; commanded by blar_ctrl.
module blar_dp #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  blar_pkg::dp_cmd_t cmd,
  input  logic              command,
  input  logic [15:0]       value,
  output logic [1:0]        status,
  output logic [4:0]        entry_count,
  output logic [15:0]       appends_done,
  output logic [15:0]       removals_done
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [15:0]         cells [CAPACITY];
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [15:0]         append_total;
  logic [15:0]         removal_total;
  logic                op;
  logic [15:0]         key;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] shift_en;
  logic                found;
  logic                has_room;
  logic [1:0]          status_next;
  logic [31:0]         count_ext;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CW'(i) < count) && (cells[i] == key);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      shift_en[i] = |(match & CAPACITY'((64'd2 << i) - 64'd1));
    end
  end

  assign found    = |match;
  assign has_room = (count < CW'(CAPACITY));

  always_comb begin
    count_next  = count;
    status_next = blar_pkg::ST_MISSING;
    if (op == blar_pkg::CMD_APPEND) begin
      if (has_room) begin
        count_next  = count + CW'(1);
        status_next = blar_pkg::ST_APPENDED;
      end else begin
        status_next = blar_pkg::ST_FULL;
      end
    end else if (found) begin
      count_next  = count - CW'(1);
      status_next = blar_pkg::ST_REMOVED;
    end
  end

  assign count_ext = 32'(count_next);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= command;
      key <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (op == blar_pkg::CMD_APPEND) begin
          if (has_room && CW'(i) == count) begin
            cells[i] <= key;
          end
        end else if (shift_en[i] && i + 1 < CAPACITY) begin
          cells[i] <= cells[(i + 1) % CAPACITY];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      append_total  <= '0;
      removal_total <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
      if (status_next == blar_pkg::ST_APPENDED) begin
        append_total <= append_total + 16'd1;
      end
      if (status_next == blar_pkg::ST_REMOVED) begin
        removal_total <= removal_total + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status        <= status_next;
      entry_count   <= count_ext[4:0];
      appends_done  <= (status_next == blar_pkg::ST_APPENDED) ? append_total + 16'd1
                                                             : append_total;
      removals_done <= (status_next == blar_pkg::ST_REMOVED) ? removal_total + 16'd1
                                                            : removal_total;
    end
  end

endmodule

FILE: sv/bounded_list_append_remove.sv
// Bounded ordered list with append and remove-by-value.
// An accepted word is loaded, then executed once the output is free (no result pending
// or the pending one taken); a new word is stalled until then. The per-cell compare,
// first-match mask and neighbor shift all complete combinationally in the execute step.
// Reset (synchronous, rst high): count and totals clear, no result pending.
// Depends on blar_pkg, blar_ctrl and blar_dp.
module bounded_list_append_remove #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        command,
  input  logic [15:0] value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [4:0]  entry_count,
  output logic [15:0] appends_done,
  output logic [15:0] removals_done
);

  blar_pkg::dp_cmd_t cmd;

  blar_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  blar_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .command       (command),
    .value         (value),
    .status        (status),
    .entry_count   (entry_count),
    .appends_done  (appends_done),
    .removals_done (removals_done)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("accepted word did not block the next one");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> result_valid)
    else $error("execute did not present a result word");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(entry_count) <= CAPACITY))
    else $error("entry count above capacity");

endmodule
